### hdl/rsch_pkg.sv
// shared types and constants for the ray closest-hit block
`timescale 1ns / 1ps
package rsch_pkg;

  localparam logic       ACT_LOAD    = 1'b0;
  localparam logic       ACT_CAST    = 1'b1;
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_PLANE  = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam int         CFG_OBJECT_COUNT = 0;
  localparam logic [30:0] DIST_MAX   = 31'h7FFF_FFFF;

  // one scene entry as held in the table memory
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] scalar;
  } entry_t;

  // request to the shared iterative math unit
  typedef struct packed {
    logic        sqrt_go;
    logic        div_go;
    logic [63:0] radicand;
    logic [62:0] numer;
    logic [31:0] denom;
  } math_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
    logic [30:0] quot;
  } math_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) sat32 = 32'sh8000_0000;
    else                           sat32 = v[31:0];
  endfunction

endpackage

### hdl/rsch_math.sv
// shared iterative unit: 64-bit integer square root and saturating divide
`timescale 1ns / 1ps
module rsch_math
  import rsch_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  math_req_t req,
  output math_rsp_t rsp
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SQRT = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam int QW = 32 + FRAC_BITS + 1;

  logic [1:0]  st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [31:0] den_r, den_nxt;
  logic [63:0] trial, rem_sh;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; done_nxt = 1'b0;
    x_nxt = x_r; res_nxt = res_r; bit_nxt = bit_r;
    rem_nxt = rem_r; q_nxt = q_r; den_nxt = den_r;
    trial  = res_r + bit_r;
    rem_sh = {rem_r[62:0], q_r[QW-1]};
    unique case (st_r)
      M_IDLE: begin
        if (req.sqrt_go) begin
          st_nxt = M_SQRT; x_nxt = req.radicand; res_nxt = '0;
          bit_nxt = 64'h4000_0000_0000_0000; cnt_nxt = 7'd32;
        end else if (req.div_go) begin
          st_nxt = M_DIV; rem_nxt = '0; den_nxt = req.denom;
          cnt_nxt = 7'(QW);
          q_nxt = req.numer[QW-FRAC_BITS-1:0] << FRAC_BITS;
        end
      end
      M_SQRT: begin
        // one result bit per cycle
        if (x_r >= trial) begin
          x_nxt = x_r - trial; res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          st_nxt = M_IDLE; done_nxt = 1'b1;
        end
      end
      M_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {32'd0, den_r}) begin
          rem_nxt = rem_sh - {32'd0, den_r};
          q_nxt = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt = {q_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          st_nxt = M_IDLE; done_nxt = 1'b1;
        end
      end
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; den_r <= den_nxt;
  end

  assign rsp.busy = (st_r != M_IDLE);
  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];
  assign rsp.quot = (|q_r[QW-1:31]) ? DIST_MAX : q_r[30:0];

endmodule

### hdl/rsch_ctrl.sv
// scene table memory and per-ray sequencer
`timescale 1ns / 1ps
module rsch_ctrl
  import rsch_pkg::*;
#(
  parameter int MAX_OBJECTS = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [229:0] in_item,
  input  logic [3:0]  object_count,
  output logic        busy,
  output logic        res_valid,
  output logic [34:0] res_data,
  output math_req_t   mreq,
  input  math_rsp_t   mrsp
);

  localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_VEC   = 4'd3;
  localparam logic [3:0] S_DOT   = 4'd4;
  localparam logic [3:0] S_DOT2  = 4'd5;
  localparam logic [3:0] S_DISC  = 4'd6;
  localparam logic [3:0] S_DISC2 = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_NUM   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  entry_t mem [MAX_OBJECTS];
  entry_t rd_r;
  logic   [MAX_OBJECTS-1:0] vld_r;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic signed [31:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic signed [31:0] ocx_r, ocy_r, ocz_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [31:0] a_r, h_r, c_r, den_r, num_r;
  logic signed [64:0] hh_r, ac_r;
  logic signed [65:0] disc_r;
  logic [62:0] n_r;
  logic        found_r, cand_r;
  logic [IW-1:0] best_i_r;
  logic [30:0] best_r;
  logic [1:0]  kind;
  logic [2:0]  slot;
  logic        load_wr;
  logic        start_sqrt, start_div;
  logic signed [32:0] d1, d2, d3;
  logic signed [33:0] n1, n2;

  function automatic logic signed [63:0] fmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    fmul = p >>> FRAC_BITS;
  endfunction

  assign slot    = in_item[3:1];
  assign load_wr = in_fire && (in_item[0] == ACT_LOAD) && (int'(slot) < MAX_OBJECTS);
  assign kind    = vld_r[idx_r[IW-1:0]] ? rd_r.kind : KIND_EMPTY;

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (load_wr)
      mem[IW'(slot)] <= {in_item[5:4], in_item[37:6], in_item[69:38],
                         in_item[101:70], in_item[229:198]};
    rd_r <= mem[idx_r[IW-1:0]];
  end

  assign d1 = 33'(ox_r) - 33'(rd_r.vx);
  assign d2 = 33'(oy_r) - 33'(rd_r.vy);
  assign d3 = 33'(oz_r) - 33'(rd_r.vz);
  assign n1 = -34'(h_r) + 34'($signed({1'b0, mrsp.root}));
  assign n2 = -34'(h_r) - 34'($signed({1'b0, mrsp.root}));

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; cnt_nxt = cnt_r;
    start_sqrt = 1'b0; start_div = 1'b0;
    unique case (st_r)
      S_IDLE:  if (in_fire && in_item[0] == ACT_CAST) begin
        idx_nxt = '0;
        cnt_nxt = (int'(object_count) > MAX_OBJECTS) ? CW'(MAX_OBJECTS)
                                                     : CW'(object_count);
        st_nxt  = S_CLEAR;
      end
      S_CLEAR: st_nxt = (cnt_r == '0) ? S_DONE : S_READ;
      S_READ:  st_nxt = S_VEC;
      S_VEC:   st_nxt = (kind == KIND_SPHERE || kind == KIND_PLANE) ? S_DOT : S_NEXT;
      S_DOT:   st_nxt = S_DOT2;
      S_DOT2:  begin
        if (kind == KIND_PLANE) begin
          if (den_r == 0 || (num_r != 0 && (num_r[31] != den_r[31]))) st_nxt = S_NEXT;
          else begin start_div = 1'b1; st_nxt = S_DIV; end
        end else st_nxt = (a_r <= 0) ? S_NEXT : S_DISC;
      end
      S_DISC:  st_nxt = S_DISC2;
      S_DISC2: if (disc_r < 0) st_nxt = S_NEXT;
               else begin start_sqrt = 1'b1; st_nxt = S_SQRT; end
      S_SQRT:  if (mrsp.done) st_nxt = S_NUM;
      S_NUM:   if (!cand_r) st_nxt = S_NEXT;
               else begin start_div = 1'b1; st_nxt = S_DIV; end
      S_DIV:   if (mrsp.done) st_nxt = S_NEXT;
      S_NEXT:  begin
        idx_nxt = idx_r + 1'b1;
        st_nxt  = (idx_r + 1'b1 >= cnt_r) ? S_DONE : S_READ;
      end
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; cnt_r <= '0; vld_r <= '0;
      found_r <= 1'b0; res_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; cnt_r <= cnt_nxt;
      res_valid <= (st_r == S_DONE);
      if (load_wr) vld_r[IW'(slot)] <= 1'b1;
      if (st_r == S_CLEAR) found_r <= 1'b0;
      if (st_r == S_DIV && mrsp.done && (!found_r || mrsp.quot < best_r)) found_r <= 1'b1;
    end
    if (st_r == S_IDLE && in_fire) begin
      ox_r <= in_item[37:6];   oy_r <= in_item[69:38];  oz_r <= in_item[101:70];
      dx_r <= in_item[133:102]; dy_r <= in_item[165:134]; dz_r <= in_item[197:166];
    end
    if (st_r == S_VEC) begin
      ocx_r <= sat32(66'(d1)); ocy_r <= sat32(66'(d2)); ocz_r <= sat32(66'(d3));
      if (kind == KIND_PLANE) begin
        p0_r <= fmul(dx_r, rd_r.vx); p1_r <= fmul(dy_r, rd_r.vy); p2_r <= fmul(dz_r, rd_r.vz);
        p3_r <= fmul(ox_r, rd_r.vx); p4_r <= fmul(oy_r, rd_r.vy); p5_r <= fmul(oz_r, rd_r.vz);
      end
    end
    if (st_r == S_DOT) begin
      if (kind == KIND_PLANE) begin
        den_r <= sat32(66'(p0_r) + 66'(p1_r) + 66'(p2_r));
        num_r <= sat32(66'(rd_r.scalar)
                 - 66'(sat32(66'(p3_r) + 66'(p4_r) + 66'(p5_r))));
      end else begin
        a_r <= sat32(66'(fmul(dx_r, dx_r)) + 66'(fmul(dy_r, dy_r)) + 66'(fmul(dz_r, dz_r)));
        h_r <= sat32(66'(fmul(ocx_r, dx_r)) + 66'(fmul(ocy_r, dy_r)) + 66'(fmul(ocz_r, dz_r)));
        c_r <= sat32(66'(sat32(66'(fmul(ocx_r, ocx_r)) + 66'(fmul(ocy_r, ocy_r))
                 + 66'(fmul(ocz_r, ocz_r)))) - 66'(sat32(66'(fmul(rd_r.scalar, rd_r.scalar)))));
      end
    end
    // a, h and c are ready here; the discriminant is ready for the test in S_DISC2
    if (st_r == S_DOT2) begin
      hh_r <= 65'(h_r) * 65'(h_r);
      ac_r <= 65'(a_r) * 65'(c_r);
    end
    if (st_r == S_DISC) disc_r <= 66'(hh_r) - 66'(ac_r);
    if (st_r == S_SQRT && mrsp.done) begin
      cand_r <= !n1[33];
      n_r    <= n2[33] ? 63'(n1) : 63'(n2);
    end
    if (st_r == S_DIV && mrsp.done && (!found_r || mrsp.quot < best_r)) begin
      best_r <= mrsp.quot; best_i_r <= idx_r[IW-1:0];
    end
  end

  assign mreq.sqrt_go  = start_sqrt;
  assign mreq.div_go   = start_div;
  assign mreq.radicand = disc_r[63:0];
  // plane numerator is |num| straight from its register, sphere numerator from the root
  assign mreq.numer    = (kind == KIND_PLANE)
                         ? (num_r[31] ? 63'(-33'(num_r)) : 63'(num_r)) : n_r;
  assign mreq.denom    = (kind == KIND_PLANE) ? (den_r[31] ? 32'(-den_r) : den_r) : a_r;

  assign busy = (st_r != S_IDLE) || res_valid;
  assign res_data = found_r ? {best_r, 3'(best_i_r), 1'b1} : 35'd0;

  a_one_go: assert property (@(posedge clk) disable iff (!rst_n) !(start_sqrt && start_div))
    else $error("sqrt and divide started together");
  a_math_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start_sqrt || start_div) |-> !mrsp.busy) else $error("math unit busy at start");
  a_done_res: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> res_valid) else $error("result lost");

endmodule

### hdl/ray_scene_closest_hit.sv
// top level of the ray closest-hit block
`timescale 1ns / 1ps
// usage:
//  in_ channel: one item per transfer, a scene load (action 0) or a ray cast (action 1)
//  out_ channel: one result per cast, none per load
//  cfg_ port: APB-style, register object_count at address 0
//  a load is written as it is taken, the next item can follow at once; a cast
//   walks the entries one by one: a sphere goes through setup, the square root
//   and the divide on the shared math unit, then the step to the next entry;
//   a plane skips the square root, an empty or unknown entry goes straight to
//   the next entry, and an entry that misses early stops short of the divide
//  the shared sqrt/divide unit, one bit per cycle, sets the rate
//  one item is in work at a time; in_tready drops while a cast runs
//  or while a result waits in the output register
//  reset clears the entry kinds (valid bits) and object_count
//  a stalled receiver holds the result in the output register
module ray_scene_closest_hit
  import rsch_pkg::*;
#(
  parameter int MAX_OBJECTS = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action, entry_index, entry_kind, vec_a_x, vec_a_y, vec_a_z, dir_x, dir_y,
  // dir_z, entry_scalar, zero pad
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_found, hit_object, hit_distance, zero pad
  output logic [39:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [3:0]  count_r;
  logic        busy, res_valid, in_fire;
  logic [34:0] res_data;
  logic [34:0] out_r;
  logic        ov_r;
  logic [229:0] item;
  math_req_t   mreq;
  math_rsp_t   mrsp;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'(CFG_OBJECT_COUNT * 4)) ? {28'd0, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'(CFG_OBJECT_COUNT * 4))
      count_r <= cfg_pwdata[3:0];
  end

  assign in_tready = !busy && !ov_r;
  assign in_fire   = in_tvalid && in_tready;
  // controller takes the fields as packed on the bus, pad dropped
  assign item = in_tdata[229:0];

  rsch_ctrl #(.MAX_OBJECTS(MAX_OBJECTS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_item(item), .object_count(count_r),
    .busy, .res_valid, .res_data, .mreq, .mrsp
  );

  rsch_math #(.FRAC_BITS(FRAC_BITS)) u_math (.clk, .rst_n, .req(mreq), .rsp(mrsp));

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_valid) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (res_valid) out_r <= res_data;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, out_r};

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !ov_r) else $error("result overwrote pending output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("stalled result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !in_tready) else $error("accepted while result pending");

endmodule
